[src/sd_spi_partial_block_read_core_macros.svh]
// Assertion macros shared by the SD SPI block read core.
// Depends on nothing; asserting files include it by name.
`ifndef SD_SPI_PARTIAL_BLOCK_READ_CORE_MACROS_SVH
`define SD_SPI_PARTIAL_BLOCK_READ_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SDSPI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked on the clock edge after the antecedent.
`define SDSPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/sdspi_pkg.sv]
// Types and constants of the SD SPI partial block read core.
// Used by sdspi_cfg and sd_spi_partial_block_read_core; depends on nothing.
package sdspi_pkg;

    localparam int BLOCK_BYTES_DEF   = 512;
    localparam int TRAILER_BYTES_DEF = 3;

    localparam int          PADDR_W          = 3;
    localparam logic [2:0]  REG_POLL_LIMIT   = 3'd0;
    localparam logic [7:0]  POLL_LIMIT_RESET = 8'd100;

    localparam logic        OP_START = 1'b0;
    localparam logic        OP_XFER  = 1'b1;

    localparam logic [7:0]  CMD17_BYTE = 8'h51;
    localparam logic [7:0]  TOKEN_BYTE = 8'hFE;
    localparam logic [7:0]  FILL_BYTE  = 8'hFF;
    localparam logic [7:0]  R1_READY   = 8'h00;

    // Last command byte index: 0x51, four address bytes, then the CRC byte.
    localparam logic [2:0]  CMD_LAST = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_CMD   = 3'd1,
        PH_RESP  = 3'd2,
        PH_TOKEN = 3'd3,
        PH_BLOCK = 3'd4,
        PH_TRAIL = 3'd5
    } phase_t;

    typedef struct packed {
        logic        op;
        logic [22:0] sector;
        logic [8:0]  byte_offset;
        logic [9:0]  read_length;
        logic [7:0]  rx_byte;
    } req_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       chip_select;
        logic       data_valid;
        logic [7:0] data_byte;
        logic       done_res;
        logic       response_timeout;
        logic       token_timeout;
    } res_t;

endpackage

[src/sdspi_cfg.sv]
// APB-style register file of the SD SPI block read core: the poll limit.
// Depends on sdspi_pkg.
module sdspi_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdspi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [7:0]                    poll_limit
);

    logic [7:0] poll_limit_reg;
    logic [7:0] poll_limit_next;
    logic       hit;

    assign hit    = (paddr == sdspi_pkg::REG_POLL_LIMIT);
    assign pready = 1'b1;

    always_comb begin
        poll_limit_next = poll_limit_reg;
        if (psel && penable && pwrite && hit) begin
            poll_limit_next = pwdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_limit_reg <= sdspi_pkg::POLL_LIMIT_RESET;
        end else begin
            poll_limit_reg <= poll_limit_next;
        end
    end

    assign prdata     = hit ? {24'd0, poll_limit_reg} : 32'd0;
    assign poll_limit = poll_limit_reg;

endmodule

[src/sd_spi_partial_block_read_core.sv]
// SD SPI partial block read core: one request per SPI byte exchange, one result each.
// Each result is registered; it appears in the cycle after its request is accepted.
// Throughput: one request per cycle while the result is taken (m_ready); the output register frees as it is.
// Reset (aresetn low, synchronous): idle phase, flags cleared, poll limit 100.
// Depends on sdspi_pkg, sdspi_cfg and sd_spi_partial_block_read_core_macros.svh.
`include "sd_spi_partial_block_read_core_macros.svh"

module sd_spi_partial_block_read_core #(
    parameter int BLOCK_BYTES   = sdspi_pkg::BLOCK_BYTES_DEF,
    parameter int TRAILER_BYTES = sdspi_pkg::TRAILER_BYTES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sdspi_pkg::req_t               s_payload,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sdspi_pkg::res_t               m_payload,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdspi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int OW  = $clog2(BLOCK_BYTES + 1);
    localparam int CW  = (OW > 8) ? OW : 8;
    localparam int XW  = ((OW > 10) ? OW : 10) + 1;

    localparam logic [XW-1:0] BLOCK_X   = XW'(BLOCK_BYTES);
    localparam logic [CW:0]   BLOCK_C   = (CW + 1)'(BLOCK_BYTES);
    localparam logic [CW:0]   TRAILER_C = (CW + 1)'(TRAILER_BYTES);

    logic [7:0] poll_limit;

    sdspi_cfg u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .poll_limit (poll_limit)
    );

    sdspi_pkg::phase_t phase_reg, phase_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [31:0]       addr_reg, addr_next;
    logic [OW-1:0]     off_reg, off_next;
    logic [OW-1:0]     end_reg, end_next;
    logic              rto_reg, rto_next;
    logic              tto_reg, tto_next;
    logic              m_valid_reg, m_valid_next;
    sdspi_pkg::res_t   res_reg, res_next;

    logic          accept;
    logic [CW:0]   cnt_inc;
    logic [CW:0]   limit_eff;
    logic [7:0]    want;
    logic          hit_want;
    logic          poll_end;
    logic [XW-1:0] off_sat;
    logic [XW-1:0] room;
    logic [XW-1:0] len_clamp;
    logic [7:0]    cmd_next;
    logic          in_window;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign cnt_inc   = {1'b0, cnt_reg} + 1'b1;
    assign limit_eff = (poll_limit == 8'd0) ? (CW + 1)'(1) : (CW + 1)'(poll_limit);
    assign want      = (phase_reg == sdspi_pkg::PH_RESP) ? sdspi_pkg::R1_READY
                                                         : sdspi_pkg::TOKEN_BYTE;
    assign hit_want  = (s_payload.rx_byte == want);
    assign poll_end  = hit_want || (cnt_inc >= limit_eff);

    // Offset saturates at the block size; the length is clamped to what is left.
    assign off_sat   = (XW'(s_payload.byte_offset) > BLOCK_X) ? BLOCK_X
                                                              : XW'(s_payload.byte_offset);
    assign room      = BLOCK_X - off_sat;
    assign len_clamp = (XW'(s_payload.read_length) > room) ? room
                                                           : XW'(s_payload.read_length);

    assign in_window = (cnt_reg >= CW'(off_reg)) && (cnt_reg < CW'(end_reg));

    // Command byte that follows the one at the current count, MSB of address first.
    always_comb begin
        case (cnt_reg[2:0])
            3'd0:    cmd_next = addr_reg[31:24];
            3'd1:    cmd_next = addr_reg[23:16];
            3'd2:    cmd_next = addr_reg[15:8];
            3'd3:    cmd_next = addr_reg[7:0];
            default: cmd_next = sdspi_pkg::FILL_BYTE;
        endcase
    end

    // Next state of the sequencer.
    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        off_next   = off_reg;
        end_next   = end_reg;
        rto_next   = rto_reg;
        tto_next   = tto_reg;
        if (accept) begin
            if (s_payload.op == sdspi_pkg::OP_START) begin
                phase_next = sdspi_pkg::PH_CMD;
                cnt_next   = '0;
                addr_next  = 32'(32'(s_payload.sector) * 32'(BLOCK_BYTES));
                off_next   = off_sat[OW-1:0];
                end_next   = OW'(off_sat + len_clamp);
                rto_next   = 1'b0;
                tto_next   = 1'b0;
            end else begin
                case (phase_reg)
                    sdspi_pkg::PH_CMD: begin
                        if (cnt_reg >= CW'(sdspi_pkg::CMD_LAST)) begin
                            phase_next = sdspi_pkg::PH_RESP;
                            cnt_next   = '0;
                        end else begin
                            cnt_next = cnt_inc[CW-1:0];
                        end
                    end
                    sdspi_pkg::PH_RESP: begin
                        cnt_next = cnt_inc[CW-1:0];
                        if (poll_end) begin
                            rto_next   = rto_reg || !hit_want;
                            phase_next = sdspi_pkg::PH_TOKEN;
                            cnt_next   = '0;
                        end
                    end
                    sdspi_pkg::PH_TOKEN: begin
                        cnt_next = cnt_inc[CW-1:0];
                        if (poll_end) begin
                            tto_next   = tto_reg || !hit_want;
                            phase_next = sdspi_pkg::PH_BLOCK;
                            cnt_next   = '0;
                        end
                    end
                    sdspi_pkg::PH_BLOCK: begin
                        cnt_next = cnt_inc[CW-1:0];
                        if (cnt_inc >= BLOCK_C) begin
                            phase_next = sdspi_pkg::PH_TRAIL;
                            cnt_next   = '0;
                        end
                    end
                    sdspi_pkg::PH_TRAIL: begin
                        cnt_next = cnt_inc[CW-1:0];
                        if (cnt_inc >= TRAILER_C) begin
                            phase_next = sdspi_pkg::PH_IDLE;
                            cnt_next   = '0;
                        end
                    end
                    default: begin
                        phase_next = sdspi_pkg::PH_IDLE;
                        cnt_next   = '0;
                    end
                endcase
            end
        end
    end

    // Result fields of the accepted request.
    always_comb begin
        res_next                  = res_reg;
        m_valid_next              = m_valid_reg && !m_ready;
        if (accept) begin
            m_valid_next          = 1'b1;
            res_next.tx_byte      = sdspi_pkg::FILL_BYTE;
            res_next.chip_select  = 1'b1;
            res_next.data_valid   = 1'b0;
            res_next.data_byte    = 8'd0;
            res_next.done_res     = 1'b0;
            if (s_payload.op == sdspi_pkg::OP_START) begin
                res_next.tx_byte = sdspi_pkg::CMD17_BYTE;
            end else begin
                case (phase_reg)
                    sdspi_pkg::PH_CMD: begin
                        if (cnt_reg < CW'(sdspi_pkg::CMD_LAST)) begin
                            res_next.tx_byte = cmd_next;
                        end
                    end
                    sdspi_pkg::PH_RESP, sdspi_pkg::PH_TOKEN: begin
                        res_next.chip_select = 1'b1;
                    end
                    sdspi_pkg::PH_BLOCK: begin
                        if (in_window) begin
                            res_next.data_valid = 1'b1;
                            res_next.data_byte  = s_payload.rx_byte;
                        end
                    end
                    sdspi_pkg::PH_TRAIL: begin
                        if (cnt_inc >= TRAILER_C) begin
                            res_next.chip_select = 1'b0;
                            res_next.done_res    = 1'b1;
                        end
                    end
                    default: begin
                        res_next.chip_select = 1'b0;
                    end
                endcase
            end
            res_next.response_timeout = rto_next;
            res_next.token_timeout    = tto_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= sdspi_pkg::PH_IDLE;
            cnt_reg     <= '0;
            addr_reg    <= '0;
            off_reg     <= '0;
            end_reg     <= '0;
            rto_reg     <= 1'b0;
            tto_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            addr_reg    <= addr_next;
            off_reg     <= off_next;
            end_reg     <= end_next;
            rto_reg     <= rto_next;
            tto_reg     <= tto_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = res_reg;

    `SDSPI_ASSERT_NEXT(a_start_enters_cmd,
        accept && (s_payload.op == sdspi_pkg::OP_START),
        (phase_reg == sdspi_pkg::PH_CMD) && (cnt_reg == '0) && !rto_reg && !tto_reg,
        "start request did not restart the command phase")

    `SDSPI_ASSERT_NEXT(a_data_only_in_block,
        accept && (s_payload.op == sdspi_pkg::OP_XFER) && (phase_reg != sdspi_pkg::PH_BLOCK),
        !m_payload.data_valid,
        "data delivered outside the block phase")

    `SDSPI_ASSERT_IMPL(a_done_releases_cs,
        m_valid && m_payload.done_res,
        !m_payload.chip_select && (phase_reg == sdspi_pkg::PH_IDLE),
        "done without chip select release and return to idle")

    `SDSPI_ASSERT_IMPL(a_block_count_range,
        phase_reg == sdspi_pkg::PH_BLOCK,
        (CW + 1)'(cnt_reg) < BLOCK_C,
        "block byte count ran past the block size")

endmodule
